// ----- rtl/sbce_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the 16-bit execute block.
// No dependencies; used by sbce_arith and sixteen_bit_cpu_execute.
package sbce_pkg;

    localparam int DATA_BYTES_DEF = 65536;

    localparam logic [15:0] ERR_PC   = 16'hFFFF;
    localparam logic [15:0] BR_MASK  = 16'h01FF;
    localparam logic [15:0] J_MASK   = 16'hF000;
    localparam logic [15:0] HI_MASK  = 16'hFF00;
    localparam logic [15:0] LO_MASK  = 16'h00FF;
    localparam logic [15:0] PC_STEP  = 16'h0002;
    localparam logic [15:0] ONE      = 16'h0001;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_AND  = 5'd2,
        OP_NOR  = 5'd3,
        OP_DIV  = 5'd4,
        OP_MUL  = 5'd5,
        OP_MOD  = 5'd6,
        OP_EXP  = 5'd7,
        OP_LW   = 5'd8,
        OP_SW   = 5'd9,
        OP_LIZ  = 5'd10,
        OP_LIS  = 5'd11,
        OP_LUI  = 5'd12,
        OP_BP   = 5'd13,
        OP_BN   = 5'd14,
        OP_BX   = 5'd15,
        OP_BZ   = 5'd16,
        OP_JR   = 5'd17,
        OP_JALR = 5'd18,
        OP_J    = 5'd19,
        OP_HALT = 5'd20,
        OP_PUT  = 5'd21
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_HALT  = 2'd1,
        ST_DIV0  = 2'd2,
        ST_ALIGN = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_S,
        S_RD_T,
        S_RD_D,
        S_EXEC,
        S_UNIT,
        S_MEM_WAIT,
        S_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        AK_DIV,
        AK_MOD,
        AK_MUL,
        AK_EXP
    } arith_kind_t;

    typedef struct packed {
        logic        start;
        arith_kind_t kind;
    } arith_req_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_DIV,
        U_EXP_MUL,
        U_EXP_SQ,
        U_DONE
    } unit_state_t;

endpackage

// ----- rtl/sbce_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
// No dependencies.
module sbce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/sbce_arith.sv -----
`timescale 1ns / 1ps
// Iterative arithmetic unit: signed div/mod (one quotient bit per cycle),
// mul and exp on one shared 16x16 multiplier. Depends on sbce_pkg.
module sbce_arith (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sbce_pkg::arith_req_t  req,
    input  logic [15:0]           a,
    input  logic [15:0]           b,
    output logic                  done,
    output logic [15:0]           result
);

    sbce_pkg::unit_state_t state_reg, state_next;
    sbce_pkg::arith_kind_t kind_reg, kind_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        neg_q_reg, neg_q_next;
    logic        neg_r_reg, neg_r_next;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] sq_reg, sq_next;
    logic [14:0] k_reg, k_next;

    logic [16:0] shifted;
    logic [16:0] diff;
    logic [15:0] mul_x;
    logic [31:0] prod;
    logic [15:0] exp_special;

    assign shifted = {rem_reg, quo_reg[15]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign mul_x   = (state_reg == sbce_pkg::U_EXP_SQ) ? sq_reg : acc_reg;
    assign prod    = mul_x * sq_reg;

    // negative exponent: only bases +1 and -1 survive
    always_comb
    begin
        if (a == sbce_pkg::ONE)
        begin
            exp_special = sbce_pkg::ONE;
        end
        else if (a == 16'hFFFF)
        begin
            exp_special = b[0] ? 16'hFFFF : sbce_pkg::ONE;
        end
        else
        begin
            exp_special = 16'h0000;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbce_pkg::U_IDLE:
            begin
                if (req.start)
                begin
                    case (req.kind)
                        sbce_pkg::AK_DIV, sbce_pkg::AK_MOD: state_next = sbce_pkg::U_DIV;
                        sbce_pkg::AK_MUL: state_next = sbce_pkg::U_EXP_MUL;
                        default:
                        begin
                            if (b[15] || (b[14:0] == 15'd0))
                            begin
                                state_next = sbce_pkg::U_DONE;
                            end
                            else
                            begin
                                state_next = sbce_pkg::U_EXP_MUL;
                            end
                        end
                    endcase
                end
            end
            sbce_pkg::U_DIV:
            begin
                if (cnt_reg == 4'd15)
                begin
                    state_next = sbce_pkg::U_DONE;
                end
            end
            sbce_pkg::U_EXP_MUL: state_next = sbce_pkg::U_EXP_SQ;
            sbce_pkg::U_EXP_SQ:
            begin
                if (k_reg[14:1] == 14'd0)
                begin
                    state_next = sbce_pkg::U_DONE;
                end
                else
                begin
                    state_next = sbce_pkg::U_EXP_MUL;
                end
            end
            sbce_pkg::U_DONE: state_next = sbce_pkg::U_IDLE;
            default: state_next = sbce_pkg::U_IDLE;
        endcase
    end

    always_comb
    begin
        kind_next  = kind_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        k_next     = k_reg;
        case (state_reg)
            sbce_pkg::U_IDLE:
            begin
                if (req.start)
                begin
                    kind_next  = req.kind;
                    rem_next   = 16'h0000;
                    quo_next   = a[15] ? (16'h0000 - a) : a;
                    dvs_next   = b[15] ? (16'h0000 - b) : b;
                    cnt_next   = 4'd0;
                    neg_q_next = a[15] ^ b[15];
                    neg_r_next = a[15];
                    case (req.kind)
                        sbce_pkg::AK_MUL:
                        begin
                            acc_next = a;
                            sq_next  = b;
                            k_next   = 15'd1;
                        end
                        sbce_pkg::AK_EXP:
                        begin
                            acc_next = b[15] ? exp_special : sbce_pkg::ONE;
                            sq_next  = a;
                            k_next   = b[14:0];
                        end
                        default:
                        begin
                            acc_next = acc_reg;
                        end
                    endcase
                end
            end
            sbce_pkg::U_DIV:
            begin
                if (!diff[16])
                begin
                    rem_next = diff[15:0];
                    quo_next = {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[15:0];
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
            end
            sbce_pkg::U_EXP_MUL:
            begin
                if (k_reg[0])
                begin
                    acc_next = prod[15:0];
                end
            end
            sbce_pkg::U_EXP_SQ:
            begin
                sq_next = prod[15:0];
                k_next  = {1'b0, k_reg[14:1]};
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_comb
    begin
        done = (state_reg == sbce_pkg::U_DONE);
        case (kind_reg)
            sbce_pkg::AK_DIV: result = neg_q_reg ? (16'h0000 - quo_reg) : quo_reg;
            sbce_pkg::AK_MOD: result = neg_r_reg ? (16'h0000 - rem_reg) : rem_reg;
            default:          result = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbce_pkg::U_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        cnt_reg   <= cnt_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        acc_reg   <= acc_next;
        sq_reg    <= sq_next;
        k_reg     <= k_next;
    end

endmodule

// ----- rtl/sixteen_bit_cpu_execute.sv -----
`timescale 1ns / 1ps
// Execute stage of a 16-bit, eight-register machine: one instruction per request.
// Aligned loads pass through a memory-wait state; mul, div/mod and exp run in the shared
// arithmetic unit, exp with two multiplier passes per exponent bit. One request in flight
// at a time; the next request is taken the cycle after the previous one commits.
// After reset the data store is swept to zero over all DATA_BYTES/2 word addresses, while
// in_stall is held high. Depends on sbce_pkg, sbce_arith and sbce_ram.
module sixteen_bit_cpu_execute #(
    parameter int DATA_BYTES = sbce_pkg::DATA_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [4:0]         op,
    input  logic [15:0]        instr_word,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        next_pc,
    output logic [1:0]         status,
    output logic               put_valid,
    output logic [2:0]         put_reg,
    output logic signed [15:0] put_value
);

    // Words are split over two byte banks: even addresses hold the high byte.
    // DATA_BYTES must be a power of two (not enforced here), so the modulo is just the low address bits.
    localparam int ADDR_W     = $clog2(DATA_BYTES);
    localparam int BANK_W     = ADDR_W - 1;
    localparam int BANK_DEPTH = DATA_BYTES / 2;

    sbce_pkg::seq_state_t state_reg, state_next;
    sbce_pkg::op_t        op_reg, op_next;
    logic [15:0]          iw_reg, iw_next;
    logic [15:0]          a_reg, a_next;
    logic [15:0]          b_reg, b_next;
    logic [15:0]          d_reg, d_next;
    logic [15:0]          res_reg, res_next;
    logic                 wr_reg, wr_next;
    logic [15:0]          npc_reg, npc_next;
    sbce_pkg::status_t    stat_reg, stat_next;
    logic                 pv_reg, pv_next;
    logic [2:0]           pr_reg, pr_next;
    logic [15:0]          pval_reg, pval_next;
    logic [15:0]          pc_reg, pc_next;
    logic [BANK_W-1:0]    clr_reg, clr_next;
    logic [15:0]          rf_reg [8];

    logic                 out_valid_reg, out_valid_next;
    logic [15:0]          o_npc_reg;
    logic [1:0]           o_stat_reg;
    logic                 o_pv_reg;
    logic [2:0]           o_pr_reg;
    logic [15:0]          o_pval_reg;

    logic [2:0]           rd;
    logic [2:0]           rs;
    logic [2:0]           rt;
    logic [2:0]           rf_raddr;
    logic [15:0]          rf_rdata;
    logic [15:0]          seq_pc;
    logic [15:0]          btarget;
    logic [15:0]          jtarget;
    logic                 commit;

    sbce_pkg::arith_req_t arith_req;
    logic                 arith_done;
    logic [15:0]          arith_result;

    logic                 ram_we;
    logic [BANK_W-1:0]    ram_addr;
    logic [7:0]           ram_wdata_hi;
    logic [7:0]           ram_wdata_lo;
    logic [7:0]           ram_rdata_hi;
    logic [7:0]           ram_rdata_lo;

    assign rd      = iw_reg[10:8];
    assign rs      = iw_reg[7:5];
    assign rt      = iw_reg[4:2];
    assign seq_pc  = pc_reg + sbce_pkg::PC_STEP;
    assign btarget = {7'd0, iw_reg[7:0], 1'b0} & sbce_pkg::BR_MASK;
    assign jtarget = (pc_reg & sbce_pkg::J_MASK) | {4'd0, iw_reg[10:0], 1'b0};

    // Finish a request once the output register is free or being drained.
    assign commit   = (state_reg == sbce_pkg::S_DONE) && !(out_valid_reg && out_stall);
    assign in_stall = (state_reg != sbce_pkg::S_IDLE);

    // One register-file read port, walked over rs, rt, rd in states S_RD_S, S_RD_T, S_RD_D.
    always_comb
    begin
        case (state_reg)
            sbce_pkg::S_RD_S: rf_raddr = rs;
            sbce_pkg::S_RD_T: rf_raddr = rt;
            default:          rf_raddr = rd;
        endcase
        rf_rdata = rf_reg[rf_raddr];
    end

    // Start the shared unit for the long operations.
    always_comb
    begin
        arith_req.start = 1'b0;
        arith_req.kind  = sbce_pkg::AK_EXP;
        case (op_reg)
            sbce_pkg::OP_DIV: arith_req.kind = sbce_pkg::AK_DIV;
            sbce_pkg::OP_MOD: arith_req.kind = sbce_pkg::AK_MOD;
            sbce_pkg::OP_MUL: arith_req.kind = sbce_pkg::AK_MUL;
            default:          arith_req.kind = sbce_pkg::AK_EXP;
        endcase
        if (state_reg == sbce_pkg::S_EXEC)
        begin
            if (op_reg inside {sbce_pkg::OP_DIV, sbce_pkg::OP_MOD})
            begin
                arith_req.start = (b_reg != 16'h0000);
            end
            else if (op_reg inside {sbce_pkg::OP_MUL, sbce_pkg::OP_EXP})
            begin
                arith_req.start = 1'b1;
            end
        end
    end

    sbce_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (arith_req),
        .a      (a_reg),
        .b      (b_reg),
        .done   (arith_done),
        .result (arith_result)
    );

    // Data store port: clearing sweep, store write at commit, otherwise read at rs.
    always_comb
    begin
        ram_we       = 1'b0;
        ram_addr     = a_reg[BANK_W:1];
        ram_wdata_hi = b_reg[15:8];
        ram_wdata_lo = b_reg[7:0];
        if (state_reg == sbce_pkg::S_CLEAR)
        begin
            ram_we       = 1'b1;
            ram_addr     = clr_reg;
            ram_wdata_hi = 8'h00;
            ram_wdata_lo = 8'h00;
        end
        else if (commit && (op_reg == sbce_pkg::OP_SW) && (stat_reg == sbce_pkg::ST_OK))
        begin
            ram_we = 1'b1;
        end
    end

    sbce_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_ram_hi (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata_hi),
        .rdata (ram_rdata_hi)
    );

    sbce_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_ram_lo (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata_lo),
        .rdata (ram_rdata_lo)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbce_pkg::S_CLEAR:
            begin
                if (clr_reg == BANK_W'(BANK_DEPTH - 1))
                begin
                    state_next = sbce_pkg::S_IDLE;
                end
            end
            sbce_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sbce_pkg::S_RD_S;
                end
            end
            sbce_pkg::S_RD_S: state_next = sbce_pkg::S_RD_T;
            sbce_pkg::S_RD_T: state_next = sbce_pkg::S_RD_D;
            sbce_pkg::S_RD_D: state_next = sbce_pkg::S_EXEC;
            sbce_pkg::S_EXEC:
            begin
                if (arith_req.start)
                begin
                    state_next = sbce_pkg::S_UNIT;
                end
                else if ((op_reg == sbce_pkg::OP_LW) && !a_reg[0])
                begin
                    state_next = sbce_pkg::S_MEM_WAIT;
                end
                else
                begin
                    state_next = sbce_pkg::S_DONE;
                end
            end
            sbce_pkg::S_UNIT:
            begin
                if (arith_done)
                begin
                    state_next = sbce_pkg::S_DONE;
                end
            end
            sbce_pkg::S_MEM_WAIT: state_next = sbce_pkg::S_DONE;
            sbce_pkg::S_DONE:
            begin
                if (commit)
                begin
                    state_next = sbce_pkg::S_IDLE;
                end
            end
            default: state_next = sbce_pkg::S_IDLE;
        endcase
    end

    // Datapath: capture the request, read operands, decode and execute.
    always_comb
    begin
        op_next   = op_reg;
        iw_next   = iw_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        d_next    = d_reg;
        res_next  = res_reg;
        wr_next   = wr_reg;
        npc_next  = npc_reg;
        stat_next = stat_reg;
        pv_next   = pv_reg;
        pr_next   = pr_reg;
        pval_next = pval_reg;
        clr_next  = clr_reg;
        case (state_reg)
            sbce_pkg::S_CLEAR: clr_next = clr_reg + BANK_W'(1);
            sbce_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = sbce_pkg::op_t'(op);
                    iw_next = instr_word;
                end
            end
            sbce_pkg::S_RD_S: a_next = rf_rdata;
            sbce_pkg::S_RD_T: b_next = rf_rdata;
            sbce_pkg::S_RD_D: d_next = rf_rdata;
            sbce_pkg::S_EXEC:
            begin
                wr_next   = 1'b0;
                stat_next = sbce_pkg::ST_OK;
                npc_next  = seq_pc;
                pv_next   = 1'b0;
                pr_next   = 3'd0;
                pval_next = 16'h0000;
                case (op_reg)
                    sbce_pkg::OP_ADD:
                    begin
                        wr_next  = 1'b1;
                        res_next = a_reg + b_reg;
                    end
                    sbce_pkg::OP_SUB:
                    begin
                        wr_next  = 1'b1;
                        res_next = a_reg - b_reg;
                    end
                    sbce_pkg::OP_AND:
                    begin
                        wr_next  = 1'b1;
                        res_next = a_reg & b_reg;
                    end
                    sbce_pkg::OP_NOR:
                    begin
                        wr_next  = 1'b1;
                        res_next = ~(a_reg | b_reg);
                    end
                    sbce_pkg::OP_DIV, sbce_pkg::OP_MOD:
                    begin
                        if (b_reg == 16'h0000)
                        begin
                            stat_next = sbce_pkg::ST_DIV0;
                            npc_next  = sbce_pkg::ERR_PC;
                        end
                        else
                        begin
                            wr_next = 1'b1;
                        end
                    end
                    sbce_pkg::OP_MUL, sbce_pkg::OP_EXP: wr_next = 1'b1;
                    sbce_pkg::OP_LW, sbce_pkg::OP_SW:
                    begin
                        if (a_reg[0])
                        begin
                            stat_next = sbce_pkg::ST_ALIGN;
                            npc_next  = sbce_pkg::ERR_PC;
                        end
                        else
                        begin
                            wr_next = (op_reg == sbce_pkg::OP_LW);
                        end
                    end
                    sbce_pkg::OP_LIZ:
                    begin
                        wr_next  = 1'b1;
                        res_next = {8'h00, iw_reg[7:0]};
                    end
                    sbce_pkg::OP_LIS:
                    begin
                        wr_next  = 1'b1;
                        res_next = {{8{iw_reg[7]}}, iw_reg[7:0]};
                    end
                    sbce_pkg::OP_LUI:
                    begin
                        wr_next  = 1'b1;
                        res_next = ({iw_reg[7:0], 8'h00} & sbce_pkg::HI_MASK)
                                   | (d_reg & sbce_pkg::LO_MASK);
                    end
                    sbce_pkg::OP_BP:
                    begin
                        if (!d_reg[15] && (d_reg != 16'h0000))
                        begin
                            npc_next = btarget;
                        end
                    end
                    sbce_pkg::OP_BN:
                    begin
                        if (d_reg[15])
                        begin
                            npc_next = btarget;
                        end
                    end
                    sbce_pkg::OP_BX:
                    begin
                        if (d_reg != 16'h0000)
                        begin
                            npc_next = btarget;
                        end
                    end
                    sbce_pkg::OP_BZ:
                    begin
                        if (d_reg == 16'h0000)
                        begin
                            npc_next = btarget;
                        end
                    end
                    sbce_pkg::OP_JR: npc_next = a_reg;
                    sbce_pkg::OP_JALR:
                    begin
                        // rd is written first, so rd == rs jumps to the link value
                        wr_next  = 1'b1;
                        res_next = seq_pc;
                        npc_next = (rd == rs) ? seq_pc : a_reg;
                    end
                    sbce_pkg::OP_J: npc_next = jtarget;
                    sbce_pkg::OP_HALT:
                    begin
                        stat_next = sbce_pkg::ST_HALT;
                        npc_next  = pc_reg;
                    end
                    sbce_pkg::OP_PUT:
                    begin
                        pv_next   = 1'b1;
                        pr_next   = rs;
                        pval_next = a_reg;
                    end
                    default:
                    begin
                        wr_next = 1'b0;
                    end
                endcase
            end
            sbce_pkg::S_UNIT:
            begin
                if (arith_done)
                begin
                    res_next = arith_result;
                end
            end
            sbce_pkg::S_MEM_WAIT: res_next = {ram_rdata_hi, ram_rdata_lo};
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // Advance the fetch address only on a clean finish.
    assign pc_next        = (commit && (stat_reg == sbce_pkg::ST_OK)) ? npc_reg : pc_reg;
    assign out_valid_next = commit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbce_pkg::S_CLEAR;
            clr_reg       <= '0;
            pc_reg        <= 16'h0000;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                rf_reg[i] <= 16'h0000;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (commit && wr_reg)
            begin
                rf_reg[rd] <= res_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        iw_reg   <= iw_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        d_reg    <= d_next;
        res_reg  <= res_next;
        wr_reg   <= wr_next;
        npc_reg  <= npc_next;
        stat_reg <= stat_next;
        pv_reg   <= pv_next;
        pr_reg   <= pr_next;
        pval_reg <= pval_next;
        if (commit)
        begin
            o_npc_reg  <= npc_reg;
            o_stat_reg <= stat_reg;
            o_pv_reg   <= pv_reg;
            o_pr_reg   <= pr_reg;
            o_pval_reg <= pval_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign next_pc   = o_npc_reg;
    assign status    = o_stat_reg;
    assign put_valid = o_pv_reg;
    assign put_reg   = o_pr_reg;
    assign put_value = o_pval_reg;

endmodule
